### src/fldsw_pkg.sv
// ----------------------------------------------------------------------------
// fldsw_pkg
// Shared types and constants of the framed link deframer with stop-and-wait
// transmit gating.
// ----------------------------------------------------------------------------
`default_nettype none

package fldsw_pkg;

    localparam int MAX_PENDING = 16;
    localparam int PEND_W      = $clog2(MAX_PENDING + 1);

    localparam logic [7:0] PREAMBLE_BYTE  = 8'hFE;
    localparam logic [7:0] POSTAMBLE_BYTE = 8'hFD;

    localparam logic [7:0] ACK_CMD_RESET  = 8'd250;
    localparam logic [7:0] NACK_CMD_RESET = 8'd251;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_QUEUE   = 2'd1,
        OP_POLL    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_CMD   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_POST  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CLS_DATA = 2'd0,
        CLS_ACK  = 2'd1,
        CLS_NACK = 2'd2
    } cls_t;

    typedef enum logic [2:0] {
        K_BODY = 3'd0,
        K_GOOD = 3'd1,
        K_BAD  = 3'd2,
        K_ACK  = 3'd3,
        K_NACK = 3'd4,
        K_SEND = 3'd5,
        K_FULL = 3'd6
    } kind_t;

    typedef enum logic {
        CFG_ACK_CMD  = 1'b0,
        CFG_NACK_CMD = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  body;
        logic [4:0]  pending;
    } res_t;

endpackage

`default_nettype wire

### src/fldsw_core.sv
// ----------------------------------------------------------------------------
// fldsw_core
// Frame state machine, pending-frame counter and ack flag; turns one
// registered item into at most one result combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module fldsw_core
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          step,
    input  wire logic [1:0]    op,
    input  wire logic [7:0]    rx_byte,
    output      logic          res_valid,
    output      fldsw_pkg::res_t res
);
    import fldsw_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [7:0]         left_reg, left_next;
    cls_t               cls_reg, cls_next;
    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic               acked_reg, acked_next;
    logic [7:0]         ack_cmd_reg;
    logic [7:0]         nack_cmd_reg;

    logic [7:0]         left_dec;
    logic               deliver;
    logic               pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_cmd_reg  <= ACK_CMD_RESET;
            nack_cmd_reg <= NACK_CMD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ACK_CMD:  ack_cmd_reg  <= cfg_data;
                CFG_NACK_CMD: nack_cmd_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            left_reg  <= '0;
            cls_reg   <= CLS_DATA;
            pend_reg  <= '0;
            acked_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            cls_reg   <= cls_next;
            pend_reg  <= pend_next;
            acked_reg <= acked_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        cls_next   = cls_reg;
        pend_next  = pend_reg;
        acked_next = acked_reg;
        res_valid  = 1'b0;
        res.kind   = K_BODY;
        res.body   = '0;
        deliver    = (cls_reg == CLS_DATA);
        pop        = 1'b0;
        left_dec   = (left_reg != 8'd0) ? left_reg - 8'd1 : left_reg;

        unique case (op_t'(op))
            OP_RX_BYTE:
            begin
                unique case (phase_reg)
                    PH_HUNT1:
                    begin
                        if (rx_byte == PREAMBLE_BYTE)
                            phase_next = PH_HUNT2;
                    end
                    PH_HUNT2:
                    begin
                        phase_next = (rx_byte == PREAMBLE_BYTE) ? PH_CMD : PH_HUNT1;
                    end
                    PH_CMD:
                    begin
                        // ack match wins when both commands are equal
                        if (rx_byte == ack_cmd_reg)
                            cls_next = CLS_ACK;
                        else if (rx_byte == nack_cmd_reg)
                            cls_next = CLS_NACK;
                        else
                            cls_next = CLS_DATA;
                        phase_next = PH_LEN;
                        if (rx_byte != ack_cmd_reg && rx_byte != nack_cmd_reg)
                        begin
                            res_valid = 1'b1;
                            res.body  = rx_byte;
                        end
                    end
                    PH_LEN:
                    begin
                        left_next  = rx_byte;
                        phase_next = (rx_byte == 8'd0) ? PH_POST : PH_DATA;
                        if (deliver)
                        begin
                            res_valid = 1'b1;
                            res.body  = rx_byte;
                        end
                    end
                    PH_DATA:
                    begin
                        left_next = left_dec;
                        if (left_dec == 8'd0)
                            phase_next = PH_POST;
                        if (deliver)
                        begin
                            res_valid = 1'b1;
                            res.body  = rx_byte;
                        end
                    end
                    PH_POST:
                    begin
                        phase_next = PH_HUNT1;
                        res_valid  = 1'b1;
                        if (rx_byte != POSTAMBLE_BYTE)
                            res.kind = K_BAD;
                        else if (cls_reg == CLS_ACK)
                        begin
                            res.kind = K_ACK;
                            pop      = 1'b1;
                        end
                        else if (cls_reg == CLS_NACK)
                            res.kind = K_NACK;
                        else
                        begin
                            res.kind = K_GOOD;
                            pop      = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT1;
                    end
                endcase
            end
            OP_QUEUE:
            begin
                if (pend_reg < PEND_W'(MAX_PENDING))
                    pend_next = pend_reg + PEND_W'(1);
                else
                begin
                    res_valid = 1'b1;
                    res.kind  = K_FULL;
                end
            end
            OP_POLL:
            begin
                if (pend_reg != '0 && acked_reg)
                begin
                    acked_next = 1'b0;
                    res_valid  = 1'b1;
                    res.kind   = K_SEND;
                end
            end
            default: ;
        endcase

        if (pop)
        begin
            if (pend_reg != '0)
                pend_next = pend_reg - PEND_W'(1);
            acked_next = 1'b1;
        end

        res.pending = 5'(pend_next);
    end

    pend_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(MAX_PENDING))
        else $error("pending count above limit");

    send_clears_ack_a: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.kind == K_SEND |=> !acked_reg)
        else $error("send grant left ack flag set");

    good_end_sets_ack_a: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && (res.kind == K_GOOD || res.kind == K_ACK)
        |=> acked_reg && phase_reg == PH_HUNT1)
        else $error("good frame end did not set ack and rehunt");

endmodule

`default_nettype wire

### src/fldsw_out_buf.sv
// ----------------------------------------------------------------------------
// fldsw_out_buf
// Result register with a skid stage, so the core can keep stepping after
// the sink stalls until the skid stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module fldsw_out_buf
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire fldsw_pkg::res_t push_data,
    output      logic            space,
    output      logic            out_valid,
    output      fldsw_pkg::res_t out_data,
    input  wire logic            out_ready
);
    import fldsw_pkg::*;

    logic  main_valid_reg;
    res_t  main_data_reg;
    logic  skid_valid_reg;
    res_t  skid_data_reg;
    logic  pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                main_valid_reg <= push;
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                main_data_reg <= skid_data_reg;
            else if (push)
                main_data_reg <= push_data;
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_data_reg <= push_data;
            else
                main_data_reg <= push_data;
        end
    end

    skid_implies_main_a: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds data while main register empty");

    no_push_when_full_a: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("result pushed into full buffer");

endmodule

`default_nettype wire

### src/framed_link_deframer_stop_and_wait.sv
// ----------------------------------------------------------------------------
// framed_link_deframer_stop_and_wait
// Byte-link deframer (FE FE cmd len data FD) with a stop-and-wait transmit
// gate: pending-frame count, ack flag and send-poll grants.
//
//   channel   direction  payload
//   s_axis    in         tuser = operation, tdata = rx_byte
//   m_axis    out        tuser = result_kind, tdata = body_byte, pending_frames
//   cfg       in         cfg_index 0 ack_command, 1 nack_command
//
// One item per cycle sustained while m_tready stays high: input register,
// combinational step logic in the core, then a result register backed by a
// one-entry skid stage. Result valid comes from the result register, so each
// result is registered in the input register and then in the result register.
// Reset restores hunting, zero pending frames, ack flag set, default commands.
// A stalled sink fills the skid stage; s_tready then drops while the input register holds an item, until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_link_deframer_stop_and_wait
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [7:0] body_byte, [12:8] pending_frames
    output      logic [2:0]  m_tuser,   // [2:0] result_kind
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import fldsw_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_byte_reg;
    logic        step;
    logic        res_valid;
    res_t        res;
    logic        space;
    res_t        out_data;

    assign step     = in_valid_reg && space;
    assign s_tready = !in_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    fldsw_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .op        (in_op_reg),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    fldsw_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tuser = out_data.kind;
    assign m_tdata = {3'b000, out_data.pending, out_data.body};

endmodule

`default_nettype wire
